>>> rtl/core/compact_id_codec_assert.svh
// Assertion macros shared by the compact identifier codec modules.
// Each macro expects a clock named clock and an active-high reset named reset.
`ifndef COMPACT_ID_CODEC_ASSERT_SVH
`define COMPACT_ID_CODEC_ASSERT_SVH

// Same-cycle implication.
`define CIC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("compact_id_codec assertion failed");

// Next-cycle implication.
`define CIC_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("compact_id_codec assertion failed");

`endif

>>> rtl/core/cic_pkg.sv
// Package of the compact identifier codec: beat types, job descriptor,
// codes, tag constants and helper functions. Depends on nothing.
`default_nettype none

package cic_pkg;

   localparam int MAX_ID_BYTES_DEF = 16;
   localparam int LEN_W            = 6;
   localparam int BITS_W           = LEN_W + 3;

   localparam logic [7:0] TAG_MASK  = 8'hC0;
   localparam logic [7:0] DATA_MASK = 8'h3F;
   localparam logic [7:0] TAG_MID   = 8'h40;
   localparam logic [7:0] TAG_HIGH  = 8'h80;
   localparam logic [7:0] LONG_RSV  = 8'h30;
   localparam logic [7:0] LONG_LEN  = 8'h0F;

   localparam logic [1:0] TAG_2B = 2'b00;
   localparam logic [1:0] TAG_4B = 2'b01;
   localparam logic [1:0] TAG_8B = 2'b10;

   localparam int BITS_2B = 14;
   localparam int BITS_4B = 30;
   localparam int BITS_8B = 62;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_TAG  = 2'd1,
      ERR_LEN  = 2'd2
   } cic_err_type;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } cic_op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_SHOW
   } cic_bk_state_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
      logic       last;
   } cic_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic [1:0] error_code;
   } cic_rsp_type;

   // One converted run: emit len bytes; byte i is b0 when i is zero and use_b0
   // is set, zero while i is below pad, else buffer entry src + i - pad.
   typedef struct packed {
      cic_err_type      err;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] pad;
      logic [LEN_W-1:0] src;
      logic             use_b0;
      logic [7:0]       b0;
      logic             bank;
   } cic_job_type;

   function automatic logic [3:0] lead_zeros(input logic [7:0] b);
      logic [3:0] n;
      logic       hit;
      n   = 4'd0;
      hit = 1'b0;
      for (int k = 7; k >= 0; k--) begin
         if (!hit && !b[k]) begin
            n = n + 4'd1;
         end else begin
            hit = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/cic_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module cic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/core/cic_job_queue.sv
// Two-entry queue of job descriptors between the loader and the emitter.
// Depends on cic_pkg.
`default_nettype none

module cic_job_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire cic_pkg::cic_job_type push_data,
   input  wire logic                pop,
   output logic                     empty,
   output cic_pkg::cic_job_type     pop_data
);

   cic_pkg::cic_job_type slot_ff [2];
   logic                 wr_ptr_ff;
   logic                 wr_ptr_in;
   logic                 rd_ptr_ff;
   logic                 rd_ptr_in;
   logic [1:0]           count_ff;
   logic [1:0]           count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

>>> rtl/core/cic_front.sv
// Loader: takes input beats into the buffer RAM bank in use and classifies
// the identifier on its last beat. Depends on cic_pkg and the assertion header.
`default_nettype none
`include "compact_id_codec_assert.svh"

module cic_front #(
   parameter int MAX_ID_BYTES = cic_pkg::MAX_ID_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire cic_pkg::cic_req_type req_data,
   input  wire logic                 done,
   output logic                      job_push,
   output cic_pkg::cic_job_type      job_data,
   output logic                      ram_we,
   output logic [$clog2(MAX_ID_BYTES + 1):0] ram_waddr,
   output logic [7:0]                ram_wdata
);

   localparam int BUF_DEPTH = MAX_ID_BYTES + 1;
   localparam int IDX_W     = $clog2(BUF_DEPTH);
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
   localparam int LW        = cic_pkg::LEN_W;
   localparam int BW        = cic_pkg::BITS_W;

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             ovf_ff;
   logic             ovf_in;
   logic [7:0]       lb_ff;
   logic [7:0]       lb_in;
   logic             nz_found_ff;
   logic             nz_found_in;
   logic [IDX_W-1:0] nz_idx_ff;
   logic [IDX_W-1:0] nz_idx_in;
   logic             bank_ff;
   logic             bank_in;
   logic [1:0]       busy_ff;
   logic [1:0]       busy_in;

   logic             accept;
   logic             room;
   logic [CNT_W-1:0] cnt_new;
   logic             ovf_new;
   logic [7:0]       lb_new;
   logic             nz_found_new;
   logic [IDX_W-1:0] nz_idx_new;

   logic [LW-1:0]    n;
   logic [3:0]       zb;
   logic [BW-1:0]    bits;
   logic [LW-1:0]    e_size;
   logic [7:0]       e_mask;
   logic [LW-1:0]    e_pad;
   logic [LW-1:0]    d_size;
   logic             d_tag_err;
   logic [7:0]       d_fb;
   logic [LW-1:0]    d_first;
   cic_pkg::cic_job_type job;

   assign accept   = req_push && !req_full;
   assign room     = (cnt_ff < CNT_W'(BUF_DEPTH));
   assign req_full = (busy_ff == 2'd2);

   always_comb begin
      cnt_new      = room ? cnt_ff + CNT_W'(1) : cnt_ff;
      ovf_new      = ovf_ff | !room;
      lb_new       = (cnt_ff == '0) ? req_data.data_byte : lb_ff;
      nz_found_new = nz_found_ff;
      nz_idx_new   = nz_idx_ff;
      if (room && (cnt_ff != '0) && (req_data.data_byte != 8'd0) && !nz_found_ff) begin
         nz_found_new = 1'b1;
         nz_idx_new   = cnt_ff[IDX_W-1:0];
      end
   end

   always_comb begin
      n    = LW'(cnt_new);
      zb   = cic_pkg::lead_zeros(lb_new);
      bits = {3'b000, n} * BW'(8) - BW'(zb);
      if (bits <= BW'(cic_pkg::BITS_2B)) begin
         e_size = LW'(2);
         e_mask = 8'h00;
      end else if (bits <= BW'(cic_pkg::BITS_4B)) begin
         e_size = LW'(4);
         e_mask = cic_pkg::TAG_MID;
      end else if (bits <= BW'(cic_pkg::BITS_8B)) begin
         e_size = LW'(8);
         e_mask = cic_pkg::TAG_HIGH;
      end else begin
         e_size = n + LW'(1);
         e_mask = cic_pkg::TAG_MASK + (8'(n) - 8'd8);
      end
      e_pad = e_size - n;

      d_tag_err = 1'b0;
      case (lb_new[7:6])
         cic_pkg::TAG_2B: d_size = LW'(2);
         cic_pkg::TAG_4B: d_size = LW'(4);
         cic_pkg::TAG_8B: d_size = LW'(8);
         default: begin
            d_tag_err = ((lb_new & cic_pkg::LONG_RSV) != 8'd0);
            d_size    = LW'(9) + LW'(lb_new & cic_pkg::LONG_LEN);
         end
      endcase
      d_fb = lb_new & cic_pkg::DATA_MASK;
      if (nz_found_new && (LW'(nz_idx_new) < d_size)) begin
         d_first = LW'(nz_idx_new);
      end else begin
         d_first = d_size - LW'(1);
      end

      job        = '0;
      job.err    = cic_pkg::ERR_NONE;
      job.len    = LW'(1);
      job.bank   = bank_ff;
      if (req_data.op == cic_pkg::OP_DECODE) begin
         if (d_tag_err) begin
            job.err = cic_pkg::ERR_TAG;
         end else if (d_size > n) begin
            job.err = cic_pkg::ERR_LEN;
         end else if (d_size <= LW'(8)) begin
            if (d_fb != 8'd0) begin
               job.len    = d_size;
               job.use_b0 = 1'b1;
               job.b0     = d_fb;
            end else begin
               job.len = d_size - d_first;
               job.src = d_first;
            end
         end else begin
            job.len = d_size - LW'(1);
            job.src = LW'(1);
         end
      end else begin
         if (ovf_new || (n > LW'(MAX_ID_BYTES)) || (n == '0)) begin
            job.err = cic_pkg::ERR_LEN;
         end else begin
            job.len    = e_size;
            job.pad    = e_pad;
            job.use_b0 = 1'b1;
            job.b0     = (e_pad != '0) ? e_mask : (lb_new | e_mask);
         end
      end
   end

   always_comb begin
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      lb_in       = lb_ff;
      nz_found_in = nz_found_ff;
      nz_idx_in   = nz_idx_ff;
      bank_in     = bank_ff;
      if (accept) begin
         if (req_data.last) begin
            cnt_in      = '0;
            ovf_in      = 1'b0;
            nz_found_in = 1'b0;
            bank_in     = ~bank_ff;
         end else begin
            cnt_in      = cnt_new;
            ovf_in      = ovf_new;
            lb_in       = lb_new;
            nz_found_in = nz_found_new;
            nz_idx_in   = nz_idx_new;
         end
      end
      busy_in = busy_ff;
      if (job_push && !done) begin
         busy_in = busy_ff + 2'd1;
      end else if (!job_push && done) begin
         busy_in = busy_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
         nz_found_ff <= 1'b0;
         bank_ff     <= 1'b0;
         busy_ff     <= 2'd0;
      end else begin
         cnt_ff      <= cnt_in;
         ovf_ff      <= ovf_in;
         nz_found_ff <= nz_found_in;
         bank_ff     <= bank_in;
         busy_ff     <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      lb_ff     <= lb_in;
      nz_idx_ff <= nz_idx_in;
   end

   assign job_push  = accept && req_data.last;
   assign job_data  = job;
   assign ram_we    = accept && room;
   assign ram_waddr = {bank_ff, cnt_ff[IDX_W-1:0]};
   assign ram_wdata = req_data.data_byte;

   `CIC_ASSERT_IMP(a_busy_limit, 1'b1, busy_ff != 2'd3)
   `CIC_ASSERT_IMP(a_done_owned, done, busy_ff != 2'd0)
   `CIC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_ff <= CNT_W'(BUF_DEPTH))
   `CIC_ASSERT_NXT(a_clear_after_last, job_push, cnt_ff == '0 && !ovf_ff)

endmodule

`default_nettype wire

>>> rtl/core/cic_back.sv
// Emitter: takes one job at a time, reads the buffer RAM and presents the
// converted run beat by beat. Depends on cic_pkg and the assertion header.
`default_nettype none
`include "compact_id_codec_assert.svh"

module cic_back #(
   parameter int MAX_ID_BYTES = cic_pkg::MAX_ID_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  job_empty,
   output logic                       job_pop,
   input  wire cic_pkg::cic_job_type  job_data,
   output logic                       ram_re,
   output logic [$clog2(MAX_ID_BYTES + 1):0] ram_raddr,
   input  wire logic [7:0]            ram_rdata,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output cic_pkg::cic_rsp_type       rsp_data,
   output logic                       done
);

   localparam int IDX_W = $clog2(MAX_ID_BYTES + 1);
   localparam int LW    = cic_pkg::LEN_W;

   cic_pkg::cic_bk_state_type state_ff;
   cic_pkg::cic_bk_state_type state_in;
   cic_pkg::cic_job_type      job_ff;
   cic_pkg::cic_job_type      job_in;
   logic [LW-1:0]             idx_ff;
   logic [LW-1:0]             idx_in;
   logic [LW-1:0]             src_idx;
   logic                      is_last;
   logic                      show;

   assign src_idx = job_ff.src + idx_ff - job_ff.pad;
   assign is_last = ((idx_ff + LW'(1)) == job_ff.len);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cic_pkg::BK_IDLE: begin
            if (!job_empty) begin
               state_in = cic_pkg::BK_FETCH;
            end
         end
         cic_pkg::BK_FETCH: begin
            state_in = cic_pkg::BK_SHOW;
         end
         cic_pkg::BK_SHOW: begin
            if (rsp_pop) begin
               state_in = is_last ? cic_pkg::BK_IDLE : cic_pkg::BK_FETCH;
            end
         end
         default: begin
            state_in = cic_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      job_pop = 1'b0;
      ram_re  = 1'b0;
      show    = 1'b0;
      job_in  = job_ff;
      idx_in  = idx_ff;
      unique case (state_ff)
         cic_pkg::BK_IDLE: begin
            job_pop = !job_empty;
            if (!job_empty) begin
               job_in = job_data;
               idx_in = '0;
            end
         end
         cic_pkg::BK_FETCH: begin
            ram_re = 1'b1;
         end
         cic_pkg::BK_SHOW: begin
            show = 1'b1;
            if (rsp_pop && !is_last) begin
               idx_in = idx_ff + LW'(1);
            end
         end
         default: begin
            show = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cic_pkg::BK_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   always_comb begin
      rsp_data.error_code = job_ff.err;
      if (job_ff.err != cic_pkg::ERR_NONE) begin
         rsp_data.out_byte = 8'd0;
         rsp_data.out_last = 1'b1;
      end else begin
         rsp_data.out_last = is_last;
         if ((idx_ff == '0) && job_ff.use_b0) begin
            rsp_data.out_byte = job_ff.b0;
         end else if (idx_ff < job_ff.pad) begin
            rsp_data.out_byte = 8'd0;
         end else begin
            rsp_data.out_byte = ram_rdata;
         end
      end
   end

   assign ram_raddr = {job_ff.bank, src_idx[IDX_W-1:0]};
   assign rsp_empty = !show;
   assign done      = show && rsp_pop && is_last;

   `CIC_ASSERT_NXT(a_fetch_then_show, state_ff == cic_pkg::BK_FETCH, state_ff == cic_pkg::BK_SHOW)
   `CIC_ASSERT_IMP(a_err_single, show && job_ff.err != cic_pkg::ERR_NONE, is_last)
   `CIC_ASSERT_NXT(a_hold_stalled, show && !rsp_pop, show && $stable(idx_ff))
   `CIC_ASSERT_IMP(a_idx_in_run, show, idx_ff < job_ff.len)

endmodule

`default_nettype wire

>>> rtl/core/compact_id_codec.sv
// Top level of the compact identifier codec: loader, job queue, emitter and
// a two-bank buffer RAM. Depends on cic_pkg, cic_front, cic_job_queue, cic_back, cic_ram.
//
// Channel  Dir  Handshake             Beat type     Fields
// req      in   req_push / req_full   cic_req_type  op, data_byte, last
// rsp      out  rsp_pop / rsp_empty   cic_rsp_type  out_byte, out_last, error_code
//
// Each input beat is taken while req_full is low; it is written to the buffer RAM while the bank has room.
// Each result beat is read from the RAM (FETCH), then presented (SHOW) until rsp_pop; each run first picks up its job.
// The loader fills one RAM bank while the emitter reads the other; req_full rises
// when two identifiers wait or are being emitted.
// Reset is synchronous; the buffer RAM is not cleared and needs no clearing pass.
`default_nettype none

module compact_id_codec #(
   parameter int MAX_ID_BYTES = cic_pkg::MAX_ID_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire cic_pkg::cic_req_type req_data,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output cic_pkg::cic_rsp_type      rsp_data
);

   localparam int IDX_W     = $clog2(MAX_ID_BYTES + 1);
   localparam int RAM_DEPTH = 2 * (2 ** IDX_W);

   cic_pkg::cic_job_type push_job;
   cic_pkg::cic_job_type head_job;
   logic                 job_push;
   logic                 job_pop;
   logic                 job_empty;
   logic                 done;
   logic                 ram_we;
   logic [IDX_W:0]       ram_waddr;
   logic [7:0]           ram_wdata;
   logic                 ram_re;
   logic [IDX_W:0]       ram_raddr;
   logic [7:0]           ram_rdata;

   cic_front #(
      .MAX_ID_BYTES(MAX_ID_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .done     (done),
      .job_push (job_push),
      .job_data (push_job),
      .ram_we   (ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata)
   );

   cic_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_data(push_job),
      .pop      (job_pop),
      .empty    (job_empty),
      .pop_data (head_job)
   );

   cic_back #(
      .MAX_ID_BYTES(MAX_ID_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .job_empty(job_empty),
      .job_pop  (job_pop),
      .job_data (head_job),
      .ram_re   (ram_re),
      .ram_raddr(ram_raddr),
      .ram_rdata(ram_rdata),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data),
      .done     (done)
   );

   cic_ram #(
      .WIDTH(8),
      .DEPTH(RAM_DEPTH)
   ) u_buffer (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

endmodule

`default_nettype wire
